### rtl/pwl_pkg.sv
// shared types, constants and helpers for the led frame sender
package pwl_pkg;

  // frame field widths
  localparam int ADDRESS_BITS    = 6;
  localparam int BRIGHTNESS_BITS = 8;
  localparam int COLOR_BITS      = 12;
  localparam int FRAME_BITS      = ADDRESS_BITS + BRIGHTNESS_BITS + COLOR_BITS;
  localparam int BITS_W          = $clog2(FRAME_BITS + 1);

  // port widths
  localparam int TICK_W     = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int ADDR_W     = 6;
  localparam int BRIGHT_W   = 8;
  localparam int COLOR_W    = 12;

  // register reset values
  localparam logic [TICK_W-1:0] START_HIGH_RST = 8'd10;
  localparam logic [TICK_W-1:0] ONE_LOW_RST    = 8'd20;
  localparam logic [TICK_W-1:0] ONE_HIGH_RST   = 8'd8;
  localparam logic [TICK_W-1:0] ZERO_LOW_RST   = 8'd10;
  localparam logic [TICK_W-1:0] ZERO_HIGH_RST  = 8'd20;
  localparam logic [TICK_W-1:0] END_LOW_RST    = 8'd30;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_HIGH = 3'd0,
    REG_ONE_LOW    = 3'd1,
    REG_ONE_HIGH   = 3'd2,
    REG_ZERO_LOW   = 3'd3,
    REG_ZERO_HIGH  = 3'd4,
    REG_END_LOW    = 3'd5
  } reg_index_t;

  // line sequencer phases
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_START,
    PH_BIT_LOW,
    PH_BIT_HIGH,
    PH_END
  } phase_t;

  // decoded command between front and back
  typedef struct packed {
    logic                  is_send;
    logic [FRAME_BITS-1:0] frame;
  } cmd_t;

  // one result beat
  typedef struct packed {
    logic line_level;
    logic drive_enabled;
    logic busy_res;
    logic send_accepted;
  } result_t;

  // segment timing registers
  typedef struct packed {
    logic [TICK_W-1:0] start_high;
    logic [TICK_W-1:0] one_low;
    logic [TICK_W-1:0] one_high;
    logic [TICK_W-1:0] zero_low;
    logic [TICK_W-1:0] zero_high;
    logic [TICK_W-1:0] end_low;
  } timing_t;

  // a zero length acts as one tick
  function automatic logic [TICK_W-1:0] seg_len(input logic [TICK_W-1:0] v);
    return (v == '0) ? TICK_W'(1) : v;
  endfunction

endpackage

### rtl/pwl_front.sv
// front stage: accepts input beats and packs them into commands
module pwl_front import pwl_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic                kind,
  input  logic [ADDR_W-1:0]   bulb_address,
  input  logic [BRIGHT_W-1:0] brightness,
  input  logic [COLOR_W-1:0]  color_word,
  output logic                cmd_push,
  input  logic                cmd_full,
  output cmd_t                cmd
);

  logic cmd_valid;
  logic take;

  // stage holds a beat until the queue takes it
  assign full     = cmd_valid && cmd_full;
  assign take     = push && !full;
  assign cmd_push = cmd_valid;

  // valid flag of the command stage
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (take) begin
      cmd_valid <= 1'b1;
    end else if (cmd_valid && !cmd_full) begin
      cmd_valid <= 1'b0;
    end
  end

  // classify and pack the frame, msb first, address leading
  always_ff @(posedge clk) begin
    if (take) begin
      cmd.is_send <= kind;
      cmd.frame   <= {bulb_address[ADDRESS_BITS-1:0],
                      brightness[BRIGHTNESS_BITS-1:0],
                      color_word[COLOR_BITS-1:0]};
    end
  end

endmodule

### rtl/pwl_cmd_fifo.sv
// two-entry command queue between front and back
module pwl_cmd_fifo import pwl_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  cmd_t wdata,
  input  logic pop,
  output logic empty,
  output cmd_t rdata
);

  cmd_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 2'd1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("cmd fifo count out of range");
  assert property (@(posedge clk) disable iff (rst)
    (!empty && !full) |-> (wr_ptr != rd_ptr))
    else $error("cmd fifo pointers disagree with count");
  assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop) |=> !empty)
    else $error("cmd fifo lost a beat");

endmodule

### rtl/pwl_back.sv
// back stage: line sequencer and result queue
module pwl_back import pwl_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  timing_t timing,
  input  logic    cmd_empty,
  input  cmd_t    cmd,
  output logic    cmd_pop,
  output result_t res,
  output logic    empty,
  input  logic    pop
);

  // sequencer state
  phase_t                phase;
  phase_t                phase_next;
  logic [TICK_W-1:0]     seg_left;
  logic [TICK_W-1:0]     seg_left_next;
  logic [FRAME_BITS-1:0] frame_shift;
  logic [FRAME_BITS-1:0] frame_shift_next;
  logic [BITS_W-1:0]     bits_left;
  logic [BITS_W-1:0]     bits_left_next;
  logic                  output_enable;
  logic                  output_enable_next;
  logic                  line_out;
  logic                  line_out_next;
  logic                  accepted;

  // shared datapath terms
  logic [TICK_W-1:0]     seg_dec;
  logic                  seg_adv;
  logic [BITS_W-1:0]     bits_dec;
  logic [FRAME_BITS-1:0] shifted;
  logic                  start_ok;
  logic                  tick_run;

  // result queue
  result_t    res_q [2];
  logic       res_wr;
  logic       res_rd;
  logic [1:0] res_count;
  logic       res_push;
  logic       res_pop;
  result_t    res_in;

  localparam logic [BITS_W-1:0] FRAME_CNT = BITS_W'(FRAME_BITS);

  // take a command whenever the result queue has room
  assign cmd_pop  = !cmd_empty && (res_count != 2'd2);
  assign res_push = cmd_pop;

  assign seg_dec  = (seg_left == '0) ? '0 : seg_left - TICK_W'(1);
  assign seg_adv  = (seg_dec == '0);
  assign bits_dec = (bits_left == '0) ? '0 : bits_left - BITS_W'(1);
  assign shifted  = {frame_shift[FRAME_BITS-2:0], 1'b0};
  assign start_ok = cmd.is_send && (phase == PH_IDLE);
  assign tick_run = !cmd.is_send && (phase != PH_IDLE);

  // next phase
  always_comb begin
    phase_next = phase;
    if (start_ok) begin
      phase_next = PH_START;
    end else if (tick_run && seg_adv) begin
      unique case (phase)
        PH_START:    phase_next = PH_BIT_LOW;
        PH_BIT_LOW:  phase_next = PH_BIT_HIGH;
        PH_BIT_HIGH: phase_next = (bits_dec != '0) ? PH_BIT_LOW : PH_END;
        default:     phase_next = PH_IDLE;
      endcase
    end
  end

  // segment counter, shifter, line and enable
  always_comb begin
    seg_left_next      = seg_left;
    frame_shift_next   = frame_shift;
    bits_left_next     = bits_left;
    output_enable_next = output_enable;
    line_out_next      = line_out;
    accepted           = 1'b0;
    if (start_ok) begin
      frame_shift_next   = cmd.frame;
      bits_left_next     = FRAME_CNT;
      output_enable_next = 1'b1;
      line_out_next      = 1'b1;
      seg_left_next      = seg_len(timing.start_high);
      accepted           = 1'b1;
    end else if (tick_run) begin
      if (!seg_adv) begin
        seg_left_next = seg_dec;
      end else begin
        unique case (phase)
          PH_START: begin
            line_out_next = 1'b0;
            seg_left_next = seg_len(frame_shift[FRAME_BITS-1] ? timing.one_low
                                                               : timing.zero_low);
          end
          PH_BIT_LOW: begin
            line_out_next = 1'b1;
            seg_left_next = seg_len(frame_shift[FRAME_BITS-1] ? timing.one_high
                                                               : timing.zero_high);
          end
          PH_BIT_HIGH: begin
            frame_shift_next = shifted;
            bits_left_next   = bits_dec;
            line_out_next    = 1'b0;
            if (bits_dec != '0) begin
              seg_left_next = seg_len(shifted[FRAME_BITS-1] ? timing.one_low
                                                             : timing.zero_low);
            end else begin
              seg_left_next = seg_len(timing.end_low);
            end
          end
          default: begin
            line_out_next = 1'b0;
            seg_left_next = '0;
          end
        endcase
      end
    end
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      seg_left      <= '0;
      bits_left     <= '0;
      output_enable <= 1'b0;
      line_out      <= 1'b0;
    end else if (cmd_pop) begin
      phase         <= phase_next;
      seg_left      <= seg_left_next;
      bits_left     <= bits_left_next;
      output_enable <= output_enable_next;
      line_out      <= line_out_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      frame_shift <= frame_shift_next;
    end
  end

  // result beat for this command
  always_comb begin
    res_in.line_level    = line_out_next;
    res_in.drive_enabled = output_enable_next;
    res_in.busy_res      = (phase_next != PH_IDLE);
    res_in.send_accepted = accepted;
  end

  // result queue control
  assign empty   = (res_count == 2'd0);
  assign res_pop = pop && !empty;
  assign res     = res_q[res_rd];

  always_ff @(posedge clk) begin
    if (rst) begin
      res_wr    <= 1'b0;
      res_rd    <= 1'b0;
      res_count <= 2'd0;
    end else begin
      if (res_push) begin
        res_wr <= ~res_wr;
      end
      if (res_pop) begin
        res_rd <= ~res_rd;
      end
      if (res_push && !res_pop) begin
        res_count <= res_count + 2'd1;
      end else if (res_pop && !res_push) begin
        res_count <= res_count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      res_q[res_wr] <= res_in;
    end
  end

  assert property (@(posedge clk) disable iff (rst) res_count != 2'd3)
    else $error("result queue count out of range");
  assert property (@(posedge clk) disable iff (rst)
    (phase == PH_IDLE) |-> !line_out)
    else $error("line high while idle");
  assert property (@(posedge clk) disable iff (rst)
    output_enable |=> output_enable)
    else $error("drive enable dropped");
  assert property (@(posedge clk) disable iff (rst)
    (res_push && res_in.send_accepted) |-> (res_in.line_level && res_in.busy_res))
    else $error("accepted send without start pulse");

endmodule

### rtl/pulse_width_led_frame_sender_unit.sv
// top level of the pulse-width led frame sender
// Sends one pulse-width coded frame per accepted send beat: 26 bits (bulb
// address, brightness, color, each msb first) after a high start pulse, each
// bit a low then a high segment, then a closing low segment. Segment lengths
// come from six 8-bit timing registers (0 acts as 1); each tick beat is one
// time step. Sends while a frame is in flight are dropped with send_accepted
// low. Every input beat yields exactly one result beat. Throughput is one
// beat per clock while neither queue is full. A result passes through the
// front stage, then the command queue, then the sequencer writes it into
// the result queue, from which it can be popped; two-entry queues let
// input and output stall independently. Timing registers should be
// written only while idle.
module pulse_width_led_frame_sender_unit import pwl_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  // configuration
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TICK_W-1:0]    cfg_data,
  // input beats
  input  logic                 push,
  output logic                 full,
  input  logic                 kind,
  input  logic [ADDR_W-1:0]    bulb_address,
  input  logic [BRIGHT_W-1:0]  brightness,
  input  logic [COLOR_W-1:0]   color_word,
  // result beats
  output logic                 empty,
  input  logic                 pop,
  output logic                 line_level,
  output logic                 drive_enabled,
  output logic                 busy_res,
  output logic                 send_accepted
);

  timing_t timing;
  cmd_t    front_cmd;
  cmd_t    head_cmd;
  logic    front_push;
  logic    fifo_full;
  logic    fifo_empty;
  logic    fifo_pop;
  result_t res;

  // timing registers
  always_ff @(posedge clk) begin
    if (rst) begin
      timing.start_high <= START_HIGH_RST;
      timing.one_low    <= ONE_LOW_RST;
      timing.one_high   <= ONE_HIGH_RST;
      timing.zero_low   <= ZERO_LOW_RST;
      timing.zero_high  <= ZERO_HIGH_RST;
      timing.end_low    <= END_LOW_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_START_HIGH: timing.start_high <= cfg_data;
        REG_ONE_LOW:    timing.one_low    <= cfg_data;
        REG_ONE_HIGH:   timing.one_high   <= cfg_data;
        REG_ZERO_LOW:   timing.zero_low   <= cfg_data;
        REG_ZERO_HIGH:  timing.zero_high  <= cfg_data;
        REG_END_LOW:    timing.end_low    <= cfg_data;
        default:        ;
      endcase
    end
  end

  // input classification
  pwl_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .kind         (kind),
    .bulb_address (bulb_address),
    .brightness   (brightness),
    .color_word   (color_word),
    .cmd_push     (front_push),
    .cmd_full     (fifo_full),
    .cmd          (front_cmd)
  );

  // decoupling queue
  pwl_cmd_fifo u_cmd_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (front_push),
    .full  (fifo_full),
    .wdata (front_cmd),
    .pop   (fifo_pop),
    .empty (fifo_empty),
    .rdata (head_cmd)
  );

  // line sequencer
  pwl_back u_back (
    .clk       (clk),
    .rst       (rst),
    .timing    (timing),
    .cmd_empty (fifo_empty),
    .cmd       (head_cmd),
    .cmd_pop   (fifo_pop),
    .res       (res),
    .empty     (empty),
    .pop       (pop)
  );

  assign line_level    = res.line_level;
  assign drive_enabled = res.drive_enabled;
  assign busy_res      = res.busy_res;
  assign send_accepted = res.send_accepted;

endmodule
